[sv/maze_explore_wall_map_step_macros.svh]
// Assertion macros shared by the wall-map explorer RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef MAZE_EXPLORE_WALL_MAP_STEP_MACROS_SVH
`define MAZE_EXPLORE_WALL_MAP_STEP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define MZEXP_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("mzexp check failed");

// Next-cycle implication, disabled while reset is asserted
`define MZEXP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("mzexp check failed");

`endif

[sv/mzexp_pkg.sv]
// Types, codes and defaults for the wall-map explorer.
// No dependencies; imported by maze_explore_wall_map_step.
`timescale 1ns / 1ps

package mzexp_pkg;

    // Field widths
    localparam int OP_W    = 2;
    localparam int DIST_W  = 16;
    localparam int TGT_W   = 4;
    localparam int HEAD_W  = 2;
    localparam int POS_W   = 4;
    localparam int WALLS_W = 8;

    // Defaults
    localparam int GRID_SIDE_DEF = 4;
    localparam logic [DIST_W-1:0] WALL_THRESHOLD_RST = 16'd100;

    // Operation codes
    typedef enum logic [OP_W-1:0] {
        OP_STEP     = 2'd0,
        OP_SET_POSE = 2'd1,
        OP_CLEAR    = 2'd2,
        OP_READ     = 2'd3
    } op_t;

    // Side codes
    localparam logic [1:0] CODE_OPEN    = 2'd0;
    localparam logic [1:0] CODE_WALL    = 2'd1;
    localparam logic [1:0] CODE_UNKNOWN = 2'd2;

    localparam logic [WALLS_W-1:0] WALLS_ALL_UNKNOWN =
        {CODE_UNKNOWN, CODE_UNKNOWN, CODE_UNKNOWN, CODE_UNKNOWN};

    // One result request
    typedef struct packed {
        logic               done;
        logic [POS_W-1:0]   position;
        logic               known;
        logic [HEAD_W-1:0]  facing;
        logic               moved;
        logic               wall;
        logic [WALLS_W-1:0] walls;
        logic               visited;
    } res_t;

endpackage

[sv/maze_explore_wall_map_step.sv]
// Wall-map explorer: pose, heading and per-cell wall/visited store on a square grid.
// Result is registered from the input register; throughput one request per cycle unless m_ready stalls.
// The rate is set by the single update pass of the pose and flop-based cell store.
// Reset (aresetn low, synchronous) clears the store to open/unvisited, pose unset,
// heading north, threshold 100; the store is in flops, so no clearing pass is needed.
// Depends on mzexp_pkg and maze_explore_wall_map_step_macros.svh.
`timescale 1ns / 1ps

`include "maze_explore_wall_map_step_macros.svh"

module maze_explore_wall_map_step #(
    parameter int GRID_SIDE = mzexp_pkg::GRID_SIDE_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mzexp_pkg::DIST_W-1:0]      cfg_data,
    // input requests
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [mzexp_pkg::OP_W-1:0]        s_operation,
    input  logic [mzexp_pkg::DIST_W-1:0]      s_distance_reading,
    input  logic [mzexp_pkg::TGT_W-1:0]       s_target_cell,
    input  logic [mzexp_pkg::HEAD_W-1:0]      s_new_heading,
    // result requests
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_done_res,
    output logic [mzexp_pkg::POS_W-1:0]       m_position,
    output logic                              m_position_known,
    output logic [mzexp_pkg::HEAD_W-1:0]      m_facing,
    output logic                              m_moved,
    output logic                              m_wall_ahead,
    output logic [mzexp_pkg::WALLS_W-1:0]     m_cell_walls,
    output logic                              m_cell_visited
);
    import mzexp_pkg::*;

    localparam int CELL_COUNT = GRID_SIDE * GRID_SIDE;
    localparam int CW         = $clog2(CELL_COUNT);
    localparam int SW         = $clog2(GRID_SIDE);
    localparam logic [SW-1:0] LAST   = SW'(GRID_SIDE - 1);
    localparam logic [SW-1:0] MID_LO = SW'((GRID_SIDE - 1) / 2);
    localparam logic [SW-1:0] MID_HI = SW'(GRID_SIDE / 2);

    // input register
    logic              in_vld_reg, in_vld_next;
    logic [OP_W-1:0]   in_op_reg;
    logic [DIST_W-1:0] in_dist_reg;
    logic [TGT_W-1:0]  in_tgt_reg;
    logic [HEAD_W-1:0] in_head_reg;

    // state
    logic [DIST_W-1:0]                  thr_reg;
    logic [SW-1:0]                      row_reg, row_next;
    logic [SW-1:0]                      col_reg, col_next;
    logic                               pose_reg, pose_next;
    logic [HEAD_W-1:0]                  head_reg, head_next;
    logic [CELL_COUNT-1:0][WALLS_W-1:0] walls_reg, walls_next;
    logic [CELL_COUNT-1:0]              visited_reg, visited_next;

    // result register
    logic m_vld_reg, m_vld_next;
    res_t res_reg, res_next;

    // datapath
    logic              fire;
    logic              step_do;
    logic              wall;
    logic              centre;
    logic              turn;
    logic [CW-1:0]     cur;
    logic [CW-1:0]     tgt_cell;
    logic              nb_ok  [4];
    logic [CW-1:0]     nb_idx [4];
    logic              en     [4];
    logic [1:0]        code   [4];
    logic [4:0]        t_rem;
    logic [1:0]        t_quo;

    // handshakes
    assign fire      = in_vld_reg && (!m_vld_reg || m_ready);
    assign s_ready   = !in_vld_reg || fire;
    assign cfg_ready = 1'b1;

    always_comb begin
        in_vld_next = in_vld_reg;
        if (s_valid && s_ready) begin
            in_vld_next = 1'b1;
        end else if (fire) begin
            in_vld_next = 1'b0;
        end
        m_vld_next = m_vld_reg;
        if (fire) begin
            m_vld_next = 1'b1;
        end else if (m_ready) begin
            m_vld_next = 1'b0;
        end
    end

    // current cell, centre test, neighbours
    assign cur      = CW'(CW'(row_reg) * CW'(GRID_SIDE)) + CW'(col_reg);
    assign tgt_cell = CW'(in_tgt_reg);
    assign centre   = (row_reg == MID_LO || row_reg == MID_HI) &&
                      (col_reg == MID_LO || col_reg == MID_HI);
    assign wall     = in_dist_reg < thr_reg;
    assign step_do  = fire && (op_t'(in_op_reg) == OP_STEP) && pose_reg;
    assign turn     = wall && !centre;

    always_comb begin
        nb_ok[0]  = row_reg != LAST;
        nb_idx[0] = cur + CW'(GRID_SIDE);
        nb_ok[1]  = col_reg != LAST;
        nb_idx[1] = cur + CW'(1);
        nb_ok[2]  = row_reg != '0;
        nb_idx[2] = cur - CW'(GRID_SIDE);
        nb_ok[3]  = col_reg != '0;
        nb_idx[3] = cur - CW'(1);
    end

    // sides recorded by a step: ahead always, right and left on a wall away from the centre
    always_comb begin
        for (int d = 0; d < 4; d++) begin
            en[d]   = (2'(d) == head_reg) ||
                      (turn && (2'(d) == head_reg + 2'd1 || 2'(d) == head_reg + 2'd3));
            code[d] = (2'(d) == head_reg) ? {1'b0, wall} : CODE_WALL;
        end
    end

    // split the target cell into row and column (quotient is at most 3)
    always_comb begin
        t_rem = 5'(in_tgt_reg);
        t_quo = 2'd0;
        for (int k = 0; k < 3; k++) begin
            if (t_rem >= 5'(GRID_SIDE)) begin
                t_rem = t_rem - 5'(GRID_SIDE);
                t_quo = t_quo + 2'd1;
            end
        end
    end

    // cell store update
    always_comb begin
        walls_next   = walls_reg;
        visited_next = visited_reg;
        if (fire && op_t'(in_op_reg) == OP_CLEAR) begin
            for (int i = 0; i < CELL_COUNT; i++) begin
                walls_next[i]   = WALLS_ALL_UNKNOWN;
                visited_next[i] = 1'b0;
            end
        end else if (step_do) begin
            for (int i = 0; i < CELL_COUNT; i++) begin
                for (int s = 0; s < 4; s++) begin
                    if (CW'(i) == cur && en[s]) begin
                        walls_next[i][2*s +: 2] = code[s];
                    end else if (nb_ok[s ^ 2] && nb_idx[s ^ 2] == CW'(i) && en[s ^ 2]) begin
                        walls_next[i][2*s +: 2] = code[s ^ 2];
                    end
                end
                if (CW'(i) == cur) begin
                    visited_next[i] = 1'b1;
                end
            end
        end
    end

    // pose update and result
    always_comb begin
        row_next  = row_reg;
        col_next  = col_reg;
        pose_next = pose_reg;
        head_next = head_reg;
        res_next  = '0;
        if (fire) begin
            case (op_t'(in_op_reg))
                OP_STEP: begin
                    if (pose_reg) begin
                        res_next.wall = wall;
                        if (centre) begin
                            res_next.done = 1'b1;
                        end else if (wall) begin
                            head_next = head_reg + 2'd2;
                        end else if (nb_ok[head_reg]) begin
                            res_next.moved = 1'b1;
                            case (head_reg)
                                2'd0:    row_next = row_reg + SW'(1);
                                2'd1:    col_next = col_reg + SW'(1);
                                2'd2:    row_next = row_reg - SW'(1);
                                default: col_next = col_reg - SW'(1);
                            endcase
                        end
                    end
                end
                OP_SET_POSE: begin
                    row_next  = SW'(t_quo);
                    col_next  = SW'(t_rem);
                    head_next = in_head_reg;
                    pose_next = 1'b1;
                end
                OP_READ: begin
                    res_next.walls   = walls_reg[tgt_cell];
                    res_next.visited = visited_reg[tgt_cell];
                end
                default: begin
                end
            endcase
        end
        res_next.position = POS_W'(CW'(CW'(row_next) * CW'(GRID_SIDE)) + CW'(col_next));
        res_next.known    = pose_next;
        res_next.facing   = head_next;
    end

    // registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            m_vld_reg   <= 1'b0;
            thr_reg     <= WALL_THRESHOLD_RST;
            row_reg     <= '0;
            col_reg     <= '0;
            pose_reg    <= 1'b0;
            head_reg    <= '0;
            walls_reg   <= '0;
            visited_reg <= '0;
        end else begin
            in_vld_reg  <= in_vld_next;
            m_vld_reg   <= m_vld_next;
            row_reg     <= row_next;
            col_reg     <= col_next;
            pose_reg    <= pose_next;
            head_reg    <= head_next;
            walls_reg   <= walls_next;
            visited_reg <= visited_next;
            if (cfg_valid && cfg_ready) begin
                thr_reg <= cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_op_reg   <= s_operation;
            in_dist_reg <= s_distance_reading;
            in_tgt_reg  <= s_target_cell;
            in_head_reg <= s_new_heading;
        end
        if (fire) begin
            res_reg <= res_next;
        end
    end

    // outputs
    assign m_valid          = m_vld_reg;
    assign m_done_res       = res_reg.done;
    assign m_position       = res_reg.position;
    assign m_position_known = res_reg.known;
    assign m_facing         = res_reg.facing;
    assign m_moved          = res_reg.moved;
    assign m_wall_ahead     = res_reg.wall;
    assign m_cell_walls     = res_reg.walls;
    assign m_cell_visited   = res_reg.visited;

    // checks
    `MZEXP_ASSERT_NOW(a_move_excl, aclk, aresetn,
        m_valid && m_moved, !m_wall_ahead && !m_done_res)
    `MZEXP_ASSERT_NOW(a_no_pose_no_step, aclk, aresetn,
        m_valid && !m_position_known, !m_moved && !m_done_res && !m_wall_ahead)
    `MZEXP_ASSERT_NEXT(a_turn_back, aclk, aresetn,
        step_do && turn, head_reg == $past(head_reg + 2'd2))
    `MZEXP_ASSERT_NEXT(a_clear_visited, aclk, aresetn,
        fire && op_t'(in_op_reg) == OP_CLEAR, visited_reg == '0)

endmodule
